// ===== rtl/assert_macros.svh =====
// assertion macros shared by the scheduler rtl
// no dependencies; included inside module bodies that have clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
// types and constants for the cooperative task scheduler
// no dependencies
package cts_pkg;

    // command codes
    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_DISP  = 2'd1;
    localparam logic [1:0] CMD_RERUN = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_RDY_FULL = 2'd1;
    localparam logic [1:0] STS_DLY_FULL = 2'd2;
    localparam logic [1:0] STS_NO_CUR   = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_POP  = 2'd2;
    localparam logic [1:0] CELL_SUB  = 2'd3;

    localparam int TASK_W = 4;
    localparam int PRIO_W = 4;
    localparam int DLY_W  = 16;
    localparam int ELAP_W = 8;

    // broadcast to every cell of one list
    typedef struct packed {
        logic [1:0]        op;
        logic [TASK_W-1:0] task_id;
        logic [DLY_W-1:0]  key;
        logic [ELAP_W-1:0] sub;
    } cell_ctrl_t;

endpackage

// ===== rtl/cooperative_task_scheduler.sv =====
// Cooperative task scheduler: command stream in, one status word out per command.
// Channels: s_tuser carries the command, s_tdata the operands; m_tdata the result.
// Both lists are rows of cts_cell slots that shift sideways to insert and pop.
// Enqueue, dispatch and rerun go through an execute step and a finish step that
// loads the result register. Tick adds a wake step between them: the wake loop
// moves one expired delayed task into the ready list per cycle while it has room.
// A new command is taken once the previous one has loaded the result register,
// even while that result still waits for m_tready.
// A stalled receiver holds the result; the next command then waits at its
// final step until the result register frees up.
// Reset empties both lists and drops the current task; it needs no clearing
// pass, so the block takes commands as soon as reset is released.
// Depth parameters set the number of cells; task and priority widths are fixed.
// includes assert_macros.svh; depends on cts_pkg and cts_cell
module cooperative_task_scheduler #(
    parameter int READY_DEPTH     = 16,
    parameter int DELAY_DEPTH     = 16,
    parameter int TASK_COUNT      = 16,
    parameter int LOWEST_PRIORITY = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // task_id[3:0], priority_req[8:4], delay_ticks[24:9],
                                  // elapsed_ticks[32:25], zero fill
    input  logic [1:0]  s_tuser,  // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // task_valid[0], dispatched_task[4:1], status[6:5],
                                  // ready_count[11:7], delayed_count[16:12],
                                  // woken_count[21:17], zero fill
);
    import cts_pkg::*;

    `include "assert_macros.svh"

    localparam int RLW = $clog2(READY_DEPTH + 1);
    localparam int DLW = $clog2(DELAY_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_WAKE   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        cmd_reg;
    logic [TASK_W-1:0] task_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [DLY_W-1:0]  delay_reg;
    logic [ELAP_W-1:0] elap_reg;
    logic              tid_ok_reg;

    logic [RLW-1:0]    rd_len_reg, rd_len_next;
    logic [DLW-1:0]    dl_len_reg, dl_len_next;
    logic [TASK_W-1:0] cur_task_reg, cur_task_next;
    logic [PRIO_W-1:0] cur_prio_reg, cur_prio_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [1:0]        status_reg, status_next;
    logic              tv_reg, tv_next;
    logic [TASK_W-1:0] disp_reg, disp_next;
    logic [DLW-1:0]    woken_reg, woken_next;

    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    cell_ctrl_t        rd_ctrl, dl_ctrl;
    logic              rd_full, dl_full, accept, out_free;

    logic [TASK_W-1:0] rd_task_w [READY_DEPTH];
    logic [PRIO_W-1:0] rd_key_w  [READY_DEPTH];
    logic [TASK_W-1:0] dl_task_w [DELAY_DEPTH];
    logic [DLY_W-1:0]  dl_key_w  [DELAY_DEPTH];

    // input field decode
    logic [TASK_W-1:0] in_task;
    logic signed [4:0] in_prio;
    logic [PRIO_W-1:0] in_prio_clamped;

    assign in_task = s_tdata[3:0];
    assign in_prio = signed'(s_tdata[8:4]);

    always_comb
    begin
        if (in_prio < 0)
            in_prio_clamped = '0;
        else if (32'(in_prio) > LOWEST_PRIORITY)
            in_prio_clamped = PRIO_W'(LOWEST_PRIORITY);
        else
            in_prio_clamped = PRIO_W'(in_prio);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_full  = (32'(rd_len_reg) >= READY_DEPTH);
    assign dl_full  = (32'(dl_len_reg) >= DELAY_DEPTH);
    assign out_free = !m_valid_reg || m_tready;

    // command register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            task_reg   <= in_task;
            prio_reg   <= in_prio_clamped;
            delay_reg  <= s_tdata[24:9];
            elap_reg   <= s_tdata[32:25];
            tid_ok_reg <= (32'(in_task) < TASK_COUNT);
        end
    end

    // list control and scheduler state
    always_comb
    begin
        state_next     = state_reg;
        rd_len_next    = rd_len_reg;
        dl_len_next    = dl_len_reg;
        cur_task_next  = cur_task_reg;
        cur_prio_next  = cur_prio_reg;
        cur_valid_next = cur_valid_reg;
        status_next    = status_reg;
        tv_next        = tv_reg;
        disp_next      = disp_reg;
        woken_next     = woken_reg;
        rd_ctrl        = '{op: CELL_HOLD, task_id: '0, key: '0, sub: '0};
        dl_ctrl        = '{op: CELL_HOLD, task_id: '0, key: '0, sub: elap_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_EXEC;
                    status_next = STS_OK;
                    tv_next     = 1'b0;
                    disp_next   = '0;
                    woken_next  = '0;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_ENQ:
                    begin
                        if (tid_ok_reg)
                        begin
                            if (rd_full)
                                status_next = STS_RDY_FULL;
                            else
                            begin
                                rd_ctrl     = '{op: CELL_INS, task_id: task_reg,
                                                key: DLY_W'(prio_reg), sub: '0};
                                rd_len_next = rd_len_reg + 1'b1;
                            end
                        end
                    end
                    CMD_DISP:
                    begin
                        if (rd_len_reg != '0)
                        begin
                            rd_ctrl        = '{op: CELL_POP, task_id: '0, key: '0, sub: '0};
                            rd_len_next    = rd_len_reg - 1'b1;
                            cur_task_next  = rd_task_w[0];
                            cur_prio_next  = rd_key_w[0];
                            cur_valid_next = 1'b1;
                            tv_next        = 1'b1;
                            disp_next      = rd_task_w[0];
                        end
                    end
                    CMD_RERUN:
                    begin
                        if (!cur_valid_reg)
                            status_next = STS_NO_CUR;
                        else if (delay_reg == '0)
                        begin
                            if (rd_full)
                                status_next = STS_RDY_FULL;
                            else
                            begin
                                rd_ctrl        = '{op: CELL_INS, task_id: cur_task_reg,
                                                   key: DLY_W'(cur_prio_reg), sub: '0};
                                rd_len_next    = rd_len_reg + 1'b1;
                                cur_valid_next = 1'b0;
                            end
                        end
                        else if (dl_full)
                            status_next = STS_DLY_FULL;
                        else
                        begin
                            dl_ctrl        = '{op: CELL_INS, task_id: cur_task_reg,
                                               key: delay_reg, sub: elap_reg};
                            dl_len_next    = dl_len_reg + 1'b1;
                            cur_valid_next = 1'b0;
                        end
                    end
                    CMD_TICK:
                    begin
                        dl_ctrl    = '{op: CELL_SUB, task_id: '0, key: '0, sub: elap_reg};
                        state_next = ST_WAKE;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WAKE:
            begin
                // expired entries form a prefix of the delay list, all at zero
                if (dl_len_reg != '0 && dl_key_w[0] == '0)
                begin
                    if (rd_full)
                    begin
                        status_next = STS_RDY_FULL;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        rd_ctrl     = '{op: CELL_INS, task_id: dl_task_w[0], key: '0,
                                        sub: '0};
                        dl_ctrl     = '{op: CELL_POP, task_id: '0, key: '0, sub: elap_reg};
                        rd_len_next = rd_len_reg + 1'b1;
                        dl_len_next = dl_len_reg - 1'b1;
                        woken_next  = woken_reg + 1'b1;
                    end
                end
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_len_reg    <= '0;
            dl_len_reg    <= '0;
            cur_task_reg  <= '0;
            cur_prio_reg  <= '0;
            cur_valid_reg <= 1'b0;
            status_reg    <= STS_OK;
            tv_reg        <= 1'b0;
            disp_reg      <= '0;
            woken_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_len_reg    <= rd_len_next;
            dl_len_reg    <= dl_len_next;
            cur_task_reg  <= cur_task_next;
            cur_prio_reg  <= cur_prio_next;
            cur_valid_reg <= cur_valid_next;
            status_reg    <= status_next;
            tv_reg        <= tv_next;
            disp_reg      <= disp_next;
            woken_reg     <= woken_next;
        end
    end

    // ready list cells
    for (genvar i = 0; i < READY_DEPTH; i++)
    begin : g_rd
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == READY_DEPTH - 1) ? i : i + 1;
        cts_cell #(.KEY_W(PRIO_W)) u_cell (
            .clk        (clk),
            .ctrl       (rd_ctrl),
            .self_valid (32'(rd_len_reg) > i),
            .left_valid ((i != 0) && (32'(rd_len_reg) > L)),
            .left_open  ((i == 0) || (32'(rd_len_reg) > L)),
            .left_task  (rd_task_w[L]),
            .left_key   (rd_key_w[L]),
            .right_task (rd_task_w[R]),
            .right_key  (rd_key_w[R]),
            .task_q     (rd_task_w[i]),
            .key_q      (rd_key_w[i])
        );
    end

    // delay list cells
    for (genvar i = 0; i < DELAY_DEPTH; i++)
    begin : g_dl
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == DELAY_DEPTH - 1) ? i : i + 1;
        cts_cell #(.KEY_W(DLY_W)) u_cell (
            .clk        (clk),
            .ctrl       (dl_ctrl),
            .self_valid (32'(dl_len_reg) > i),
            .left_valid ((i != 0) && (32'(dl_len_reg) > L)),
            .left_open  ((i == 0) || (32'(dl_len_reg) > L)),
            .left_task  (dl_task_w[L]),
            .left_key   (dl_key_w[L]),
            .right_task (dl_task_w[R]),
            .right_key  (dl_key_w[R]),
            .task_q     (dl_task_w[i]),
            .key_q      (dl_key_w[i])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (state_reg == ST_FINISH && out_free)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
            m_data_reg <= {2'b0, 5'(woken_reg), 5'(dl_len_reg), 5'(rd_len_reg),
                           status_reg, disp_reg, tv_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `CTS_ASSERT(a_rd_len, 32'(rd_len_reg) <= READY_DEPTH, "ready list overflow")
    `CTS_ASSERT(a_dl_len, 32'(dl_len_reg) <= DELAY_DEPTH, "delay list overflow")
    `CTS_ASSERT_IMP(a_out_src, $rose(m_tvalid), $past(state_reg) == ST_FINISH,
                    "result loaded outside finish step")
    `CTS_ASSERT_IMP(a_wake_only_tick, state_reg == ST_WAKE, cmd_reg == CMD_TICK,
                    "wake loop entered for a non-tick command")

endmodule

// ===== rtl/cts_cell.sv =====
// one slot of a sorted list: task number and sort key
// depends on cts_pkg
module cts_cell #(
    parameter int KEY_W = 4
) (
    input  logic                      clk,
    input  cts_pkg::cell_ctrl_t       ctrl,
    input  logic                      self_valid,
    input  logic                      left_valid,
    input  logic                      left_open,
    input  logic [cts_pkg::TASK_W-1:0] left_task,
    input  logic [KEY_W-1:0]          left_key,
    input  logic [cts_pkg::TASK_W-1:0] right_task,
    input  logic [KEY_W-1:0]          right_key,
    output logic [cts_pkg::TASK_W-1:0] task_q,
    output logic [KEY_W-1:0]          key_q
);
    import cts_pkg::*;

    logic [TASK_W-1:0] task_reg, task_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  new_key;
    logic [KEY_W+7:0]  key_ext, sub_ext;
    logic              left_gt, self_gt;

    assign new_key = ctrl.key[KEY_W-1:0];
    assign key_ext = {8'b0, key_reg};
    assign sub_ext = {{KEY_W{1'b0}}, ctrl.sub};
    assign left_gt = left_valid && (left_key > new_key);
    assign self_gt = self_valid && (key_reg > new_key);

    // next slot contents
    always_comb
    begin
        task_next = task_reg;
        key_next  = key_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (left_gt)
                begin
                    task_next = left_task;
                    key_next  = left_key;
                end
                else if (self_gt || (!self_valid && left_open))
                begin
                    task_next = ctrl.task_id;
                    key_next  = new_key;
                end
            end
            CELL_POP:
            begin
                task_next = right_task;
                key_next  = right_key;
            end
            CELL_SUB:
            begin
                // saturate at zero: expired entries read as zero
                if (key_ext > sub_ext)
                    key_next = KEY_W'(key_ext - sub_ext);
                else
                    key_next = '0;
            end
            default:
            begin
                task_next = task_reg;
                key_next  = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        key_reg  <= key_next;
    end

    assign task_q = task_reg;
    assign key_q  = key_reg;

endmodule
